// ----- sv/pcd_pkg.sv -----
// ----------------------------------------------------------------------------
// pcd_pkg: shared types, constants and helpers for the dimmer controller
// Holds the event and mode codes, the level constants, the result record
// passed from the core to the top level and the divide-by-ten helpers.
// ----------------------------------------------------------------------------
package pcd_pkg;

  typedef enum logic [2:0] {
    ACT_ZERO_CROSS = 3'd0,
    ACT_TIMEOUT    = 3'd1,
    ACT_SET_LEVEL  = 3'd2,
    ACT_ON_OFF     = 3'd3,
    ACT_STEP_UP    = 3'd4,
    ACT_STEP_DOWN  = 3'd5,
    ACT_WAKE_UP    = 3'd6
  } pcd_action_t;

  typedef enum logic [1:0] {
    MODE_OFF  = 2'd0,
    MODE_ON   = 2'd1,
    MODE_DIM  = 2'd2,
    MODE_WAKE = 2'd3
  } pcd_mode_t;

  localparam int unsigned LEVEL_W = 7;
  localparam int unsigned COUNT_W = 8;
  localparam int unsigned DELAY_W = 4;

  localparam logic [LEVEL_W-1:0] LEVEL_RESET = 7'd50;
  localparam logic [LEVEL_W-1:0] LEVEL_STEP  = 7'd10;
  localparam logic [LEVEL_W-1:0] LEVEL_FULL  = 7'd100;
  localparam logic [LEVEL_W-1:0] LEVEL_TOP   = 7'd90;
  localparam logic [LEVEL_W-1:0] SET_ON_MIN  = 7'd95;
  localparam logic [LEVEL_W-1:0] SET_OFF_MAX = 7'd5;
  localparam logic [3:0]         HALF_STEP   = 4'd5;
  localparam logic [COUNT_W-1:0] RAMP_HOLD_RESET = 8'd50;

  // Reciprocal of ten scaled by 2^11; exact for operands below 128.
  localparam logic [14:0] RECIP_TEN   = 15'd205;
  localparam int unsigned RECIP_SHIFT = 11;

  typedef struct packed {
    logic               gate_on;
    logic               timer_start;
    logic [DELAY_W-1:0] timer_delay;
    pcd_mode_t          mode;
    logic [LEVEL_W-1:0] level;
  } pcd_result_t;

  function automatic logic [LEVEL_W-1:0] round_to_ten(input logic [LEVEL_W-1:0] v);
    logic [14:0]        prod;
    logic [3:0]         q;
    logic [LEVEL_W-1:0] tens;
    logic [3:0]         r;
    prod = 15'(v) * RECIP_TEN;
    q    = 4'(prod >> RECIP_SHIFT);
    tens = 7'(q) * LEVEL_STEP;
    r    = 4'(v - tens);
    if (r >= HALF_STEP) begin
      return tens + LEVEL_STEP;
    end
    return tens;
  endfunction

  function automatic logic [DELAY_W-1:0] delay_of(input logic [LEVEL_W-1:0] lvl);
    logic [LEVEL_W-1:0] d;
    logic [14:0]        prod;
    d    = LEVEL_FULL - lvl;
    prod = 15'(d) * RECIP_TEN;
    if (lvl > LEVEL_FULL) begin
      return '0;
    end
    return DELAY_W'(prod >> RECIP_SHIFT);
  endfunction

endpackage

// ----- sv/phase_cut_dimmer_control_top.sv -----
// ----------------------------------------------------------------------------
// phase_cut_dimmer_control_top: phase-cut dimmer controller
// Takes one event per item on the slave stream and returns one status item
// per event on the master stream: gate level, timer request, mode and level.
//
// The slave stream carries an event code and a value. Each accepted item is
// held in an input register, decoded against the dimmer state, and the
// status lands in an output register that drives the master side. One item
// per cycle is sustained while m_tready stays high; the single decode stage
// between the two registers sets that. While a status item waits, the next
// event may still sit in the input register; further input is refused only
// when both registers are full, so a stalled receiver holds everything
// without loss. Reset clears the valid flags of both registers and puts the
// dimmer in off mode at level fifty with the gate low and the ramp hold
// count at fifty. The user writes the ramp hold count through cfg_wr_en and
// cfg_wr_data only while no event is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module phase_cut_dimmer_control_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // action [2:0], value [9:3], zero fill
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // gate_on [0], timer_start [1], timer_delay [5:2],
                                 // mode [7:6], level [14:8], zero fill
);

  logic                          in_valid;
  pcd_pkg::pcd_action_t          in_action;
  logic [pcd_pkg::LEVEL_W-1:0]   in_value;
  logic                          out_valid;
  logic [15:0]                   out_data;
  logic                          fire;
  logic                          take;
  pcd_pkg::pcd_result_t          res;

  assign fire     = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || fire;
  assign take     = s_tvalid && s_tready;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  pcd_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .fire        (fire),
    .action      (in_action),
    .value       (in_value),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        in_valid <= 1'b1;
      end else if (fire) begin
        in_valid <= 1'b0;
      end
      if (fire) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_action <= pcd_pkg::pcd_action_t'(s_tdata[2:0]);
      in_value  <= s_tdata[9:3];
    end
    if (fire) begin
      out_data <= {1'b0, res.level, res.mode, res.timer_delay, res.timer_start, res.gate_on};
    end
  end

  a_item_moves_out: assert property (@(posedge clk) disable iff (rst)
    in_valid && !out_valid |=> out_valid)
    else $error("Pending item did not reach the output register.");

  a_no_accept_when_full: assert property (@(posedge clk) disable iff (rst)
    in_valid && out_valid && !m_tready |-> !s_tready)
    else $error("Input accepted while both registers are held.");

  a_timer_delay_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data[5:2] <= 4'd10 && (out_data[1] || out_data[5:2] == 4'd0))
    else $error("Timer delay out of range or set without a timer start.");

endmodule

// ----- sv/pcd_core.sv -----
// ----------------------------------------------------------------------------
// pcd_core: dimmer state and event decode
// Holds the mode, level, ramp counter and gate state together with the ramp
// hold register, and works out the result and next state for one event.
// ----------------------------------------------------------------------------
module pcd_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [pcd_pkg::COUNT_W-1:0]    cfg_wr_data,
  input  logic                           fire,
  input  pcd_pkg::pcd_action_t           action,
  input  logic [pcd_pkg::LEVEL_W-1:0]    value,
  output pcd_pkg::pcd_result_t           res
);

  pcd_pkg::pcd_mode_t               mode_reg, mode_next;
  logic [pcd_pkg::LEVEL_W-1:0]      level_reg, level_next;
  logic [pcd_pkg::COUNT_W-1:0]      ramp_count, ramp_count_next;
  logic                             gate_reg, gate_next;
  logic [pcd_pkg::COUNT_W-1:0]      ramp_hold_count;

  logic                             active;
  logic                             wake_step;
  logic [pcd_pkg::LEVEL_W-1:0]      wake_level;
  logic [pcd_pkg::COUNT_W-1:0]      wake_count;
  logic                             zc_active;

  assign active     = (mode_reg == pcd_pkg::MODE_DIM) || (mode_reg == pcd_pkg::MODE_WAKE);
  assign wake_step  = (ramp_count == ramp_hold_count);
  assign wake_level = wake_step ? level_reg + pcd_pkg::LEVEL_STEP : level_reg;
  assign wake_count = (wake_step ? '0 : ramp_count) + 8'd1;
  assign zc_active  = (action == pcd_pkg::ACT_ZERO_CROSS) && active;

  always_comb begin
    mode_next       = mode_reg;
    level_next      = level_reg;
    ramp_count_next = ramp_count;
    gate_next       = gate_reg;
    unique case (action)
      pcd_pkg::ACT_ZERO_CROSS: begin
        if (active) begin
          gate_next = 1'b0;
        end
      end
      pcd_pkg::ACT_TIMEOUT: begin
        if (active) begin
          gate_next = 1'b1;
          if (mode_reg == pcd_pkg::MODE_WAKE) begin
            level_next      = wake_level;
            ramp_count_next = wake_count;
            if (wake_level >= pcd_pkg::LEVEL_FULL) begin
              level_next = pcd_pkg::LEVEL_TOP;
              mode_next  = pcd_pkg::MODE_ON;
            end
          end
        end
      end
      pcd_pkg::ACT_SET_LEVEL: begin
        if (value >= pcd_pkg::SET_ON_MIN) begin
          mode_next = pcd_pkg::MODE_ON;
          gate_next = 1'b1;
        end else if (value <= pcd_pkg::SET_OFF_MAX) begin
          mode_next = pcd_pkg::MODE_OFF;
          gate_next = 1'b0;
        end else begin
          level_next = pcd_pkg::round_to_ten(value);
          mode_next  = pcd_pkg::MODE_DIM;
          gate_next  = 1'b0;
        end
      end
      pcd_pkg::ACT_ON_OFF: begin
        if (value != '0) begin
          mode_next = pcd_pkg::MODE_ON;
          gate_next = 1'b1;
        end else begin
          mode_next = pcd_pkg::MODE_OFF;
          gate_next = 1'b0;
        end
      end
      pcd_pkg::ACT_STEP_UP: begin
        unique case (mode_reg)
          pcd_pkg::MODE_OFF: begin
            level_next = pcd_pkg::LEVEL_STEP;
            mode_next  = pcd_pkg::MODE_DIM;
          end
          pcd_pkg::MODE_ON: begin
            mode_next = pcd_pkg::MODE_OFF;
            gate_next = 1'b0;
          end
          pcd_pkg::MODE_DIM: begin
            if (level_reg >= pcd_pkg::LEVEL_TOP) begin
              mode_next = pcd_pkg::MODE_ON;
              gate_next = 1'b1;
            end else begin
              level_next = level_reg + pcd_pkg::LEVEL_STEP;
            end
          end
          pcd_pkg::MODE_WAKE: begin
          end
          default: begin
          end
        endcase
      end
      pcd_pkg::ACT_STEP_DOWN: begin
        unique case (mode_reg)
          pcd_pkg::MODE_ON: begin
            level_next = pcd_pkg::LEVEL_TOP;
            mode_next  = pcd_pkg::MODE_DIM;
          end
          pcd_pkg::MODE_OFF: begin
            mode_next = pcd_pkg::MODE_ON;
            gate_next = 1'b1;
          end
          pcd_pkg::MODE_DIM: begin
            if (level_reg <= pcd_pkg::LEVEL_STEP) begin
              mode_next = pcd_pkg::MODE_OFF;
              gate_next = 1'b0;
            end else begin
              level_next = level_reg - pcd_pkg::LEVEL_STEP;
            end
          end
          pcd_pkg::MODE_WAKE: begin
          end
          default: begin
          end
        endcase
      end
      pcd_pkg::ACT_WAKE_UP: begin
        level_next = pcd_pkg::LEVEL_STEP;
        mode_next  = pcd_pkg::MODE_WAKE;
        gate_next  = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res.gate_on     = gate_next;
    res.timer_start = zc_active;
    res.timer_delay = zc_active ? pcd_pkg::delay_of(level_reg) : '0;
    res.mode        = mode_next;
    res.level       = level_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg        <= pcd_pkg::MODE_OFF;
      level_reg       <= pcd_pkg::LEVEL_RESET;
      ramp_count      <= '0;
      gate_reg        <= 1'b0;
      ramp_hold_count <= pcd_pkg::RAMP_HOLD_RESET;
    end else begin
      if (cfg_wr_en) begin
        ramp_hold_count <= cfg_wr_data;
      end
      if (fire) begin
        mode_reg   <= mode_next;
        level_reg  <= level_next;
        ramp_count <= ramp_count_next;
        gate_reg   <= gate_next;
      end
    end
  end

  a_level_bounded: assert property (@(posedge clk) disable iff (rst)
    level_reg <= pcd_pkg::LEVEL_FULL)
    else $error("Dimmer level has gone above full scale.");

  a_timer_only_active: assert property (@(posedge clk) disable iff (rst)
    res.timer_start |-> (mode_reg == pcd_pkg::MODE_DIM || mode_reg == pcd_pkg::MODE_WAKE))
    else $error("Timer started outside dim or wake-up mode.");

  a_wake_start: assert property (@(posedge clk) disable iff (rst)
    fire && action == pcd_pkg::ACT_WAKE_UP |=>
      mode_reg == pcd_pkg::MODE_WAKE && level_reg == pcd_pkg::LEVEL_STEP && !gate_reg)
    else $error("Wake-up start did not enter the ramp at the first step.");

  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(mode_reg) && $stable(level_reg) && $stable(ramp_count))
    else $error("Dimmer state changed without an item.");

endmodule

// ----- tb/tb_phase_cut_dimmer_control_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_phase_cut_dimmer_control_top: self-checking bench for the dimmer control
// Drives event items with random gaps against a receiver that stalls at
// random, predicts each status item from a local model of the dimmer state
// and compares every status field. The ramp hold count is rewritten between
// phases while no event is in flight.
// ----------------------------------------------------------------------------
module tb_phase_cut_dimmer_control_top;

  localparam logic [2:0] ACT_UNUSED  = 3'd7;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned MAX_REPORTS = 10;

  class dimmer_status_board;
    pcd_pkg::pcd_mode_t                   mode_q;
    logic [pcd_pkg::LEVEL_W-1:0]          level_q;
    logic [pcd_pkg::COUNT_W-1:0]          ramp_cnt;
    logic [pcd_pkg::COUNT_W-1:0]          hold_cnt;
    logic                                 gate_q;
    pcd_pkg::pcd_result_t                 expected_status[$];
    int unsigned                          fail_count;

    function new();
      mode_q     = pcd_pkg::MODE_OFF;
      level_q    = pcd_pkg::LEVEL_RESET;
      ramp_cnt   = '0;
      hold_cnt   = pcd_pkg::RAMP_HOLD_RESET;
      gate_q     = 1'b0;
      fail_count = 0;
    endfunction

    function void set_hold(logic [pcd_pkg::COUNT_W-1:0] v);
      hold_cnt = v;
    endfunction

    function void note_event(logic [2:0] act, logic [pcd_pkg::LEVEL_W-1:0] val);
      pcd_pkg::pcd_result_t        res;
      logic                        tstart;
      logic [pcd_pkg::DELAY_W-1:0] tdelay;
      logic                        active;
      int                          v;
      int                          rem;
      tstart = 1'b0;
      tdelay = '0;
      active = (mode_q == pcd_pkg::MODE_DIM) || (mode_q == pcd_pkg::MODE_WAKE);
      case (act)
        pcd_pkg::ACT_ZERO_CROSS: begin
          if (active) begin
            gate_q = 1'b0;
            tstart = 1'b1;
            tdelay = (level_q <= pcd_pkg::LEVEL_FULL) ?
                     pcd_pkg::DELAY_W'((int'(pcd_pkg::LEVEL_FULL) - int'(level_q)) / 10) :
                     '0;
          end
        end
        pcd_pkg::ACT_TIMEOUT: begin
          if (active) begin
            gate_q = 1'b1;
            if (mode_q == pcd_pkg::MODE_WAKE) begin
              if (ramp_cnt == hold_cnt) begin
                level_q  = level_q + pcd_pkg::LEVEL_STEP;
                ramp_cnt = '0;
              end
              ramp_cnt = ramp_cnt + 1'b1;
              if (level_q >= pcd_pkg::LEVEL_FULL) begin
                level_q = pcd_pkg::LEVEL_TOP;
                mode_q  = pcd_pkg::MODE_ON;
              end
            end
          end
        end
        pcd_pkg::ACT_SET_LEVEL: begin
          if (val >= pcd_pkg::SET_ON_MIN) begin
            mode_q = pcd_pkg::MODE_ON;
            gate_q = 1'b1;
          end else if (val <= pcd_pkg::SET_OFF_MAX) begin
            mode_q = pcd_pkg::MODE_OFF;
            gate_q = 1'b0;
          end else begin
            v   = int'(val);
            rem = v % 10;
            level_q = (rem >= 5) ? pcd_pkg::LEVEL_W'(v + 10 - rem) :
                                   pcd_pkg::LEVEL_W'(v - rem);
            mode_q  = pcd_pkg::MODE_DIM;
            gate_q  = 1'b0;
          end
        end
        pcd_pkg::ACT_ON_OFF: begin
          mode_q = (val != 0) ? pcd_pkg::MODE_ON : pcd_pkg::MODE_OFF;
          gate_q = (val != 0);
        end
        pcd_pkg::ACT_STEP_UP: begin
          case (mode_q)
            pcd_pkg::MODE_OFF: begin
              level_q = pcd_pkg::LEVEL_STEP;
              mode_q  = pcd_pkg::MODE_DIM;
            end
            pcd_pkg::MODE_ON: begin
              mode_q = pcd_pkg::MODE_OFF;
              gate_q = 1'b0;
            end
            pcd_pkg::MODE_DIM: begin
              if (level_q >= pcd_pkg::LEVEL_TOP) begin
                mode_q = pcd_pkg::MODE_ON;
                gate_q = 1'b1;
              end else begin
                level_q = level_q + pcd_pkg::LEVEL_STEP;
              end
            end
            default: ;
          endcase
        end
        pcd_pkg::ACT_STEP_DOWN: begin
          case (mode_q)
            pcd_pkg::MODE_ON: begin
              level_q = pcd_pkg::LEVEL_TOP;
              mode_q  = pcd_pkg::MODE_DIM;
            end
            pcd_pkg::MODE_OFF: begin
              mode_q = pcd_pkg::MODE_ON;
              gate_q = 1'b1;
            end
            pcd_pkg::MODE_DIM: begin
              if (level_q <= pcd_pkg::LEVEL_STEP) begin
                mode_q = pcd_pkg::MODE_OFF;
                gate_q = 1'b0;
              end else begin
                level_q = level_q - pcd_pkg::LEVEL_STEP;
              end
            end
            default: ;
          endcase
        end
        pcd_pkg::ACT_WAKE_UP: begin
          level_q = pcd_pkg::LEVEL_STEP;
          mode_q  = pcd_pkg::MODE_WAKE;
          gate_q  = 1'b0;
        end
        default: ;
      endcase
      res.gate_on     = gate_q;
      res.timer_start = tstart;
      res.timer_delay = tdelay;
      res.mode        = mode_q;
      res.level       = level_q;
      expected_status.push_back(res);
    endfunction

    function void report(string msg);
      fail_count++;
      if (fail_count <= MAX_REPORTS) begin
        $display("ERROR at %0t: %s", $realtime, msg);
      end
    endfunction

    function void check_status(logic [15:0] word);
      pcd_pkg::pcd_result_t got;
      pcd_pkg::pcd_result_t exp;
      got.gate_on     = word[0];
      got.timer_start = word[1];
      got.timer_delay = word[5:2];
      got.mode        = pcd_pkg::pcd_mode_t'(word[7:6]);
      got.level       = word[14:8];
      if (expected_status.size() == 0) begin
        report($sformatf("status item 0x%04h with no event waiting", word));
        return;
      end
      exp = expected_status.pop_front();
      if (got.gate_on != exp.gate_on || got.timer_start != exp.timer_start ||
          got.timer_delay != exp.timer_delay || got.mode != exp.mode ||
          got.level != exp.level) begin
        report($sformatf({"expected gate %0d start %0d delay %0d mode %0d level %0d, ",
                          "got gate %0d start %0d delay %0d mode %0d level %0d"},
                         exp.gate_on, exp.timer_start, exp.timer_delay, exp.mode,
                         exp.level, got.gate_on, got.timer_start, got.timer_delay,
                         got.mode, got.level));
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_wr_en;
  logic [7:0]  cfg_wr_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;   // action [2:0], value [9:3], zero fill
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;   // gate_on [0], timer_start [1], timer_delay [5:2],
                          // mode [7:6], level [14:8], zero fill

  dimmer_status_board board = new();
  int unsigned        cycle_count = 0;
  int unsigned        burst_left = 0;

  phase_cut_dimmer_control_top u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("phase_cut_dimmer_control_top test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        board.note_event(s_tdata[2:0], s_tdata[9:3]);
      end
      if (m_tvalid && m_tready) begin
        board.check_status(m_tdata);
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 40);
  endfunction

  initial begin
    int unsigned run;
    int unsigned r;
    bit          rdy;
    m_tready = 1'b0;
    forever begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        run = $urandom_range(1, 8);
        rdy = 1'b1;
      end else if (r < 55) begin
        run = $urandom_range(50, 200);
        rdy = 1'b1;
      end else begin
        run = pick_gap() + 1;
        rdy = 1'b0;
      end
      repeat (run) begin
        m_tready <= rdy;
        @(posedge clk);
      end
    end
  end

  task automatic send_event(logic [2:0] act, logic [pcd_pkg::LEVEL_W-1:0] val);
    int unsigned gap;
    s_tvalid <= 1'b1;
    s_tdata  <= {6'd0, val, act};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else begin
      if ($urandom_range(0, 99) < 3) begin
        burst_left = $urandom_range(20, 60);
      end
      gap = pick_gap();
    end
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (board.expected_status.size() != 0) @(posedge clk);
  endtask

  task automatic write_hold(logic [7:0] v);
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    board.set_hold(v);
  endtask

  function automatic logic [pcd_pkg::LEVEL_W-1:0] rand_value();
    if ($urandom_range(0, 9) == 0) begin
      return pcd_pkg::LEVEL_W'($urandom_range(0, 127));
    end
    return pcd_pkg::LEVEL_W'($urandom_range(0, 100));
  endfunction

  task automatic run_phase(int unsigned budget, bit mid_drain);
    int unsigned sent;
    int unsigned r;
    int unsigned k;
    bit          drained;
    sent    = 0;
    drained = 1'b0;
    while (sent < budget) begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        k = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 150) : $urandom_range(1, 20);
        if (2 * k > budget - sent) begin
          k = (budget - sent + 1) / 2;
        end
        repeat (k) begin
          send_event(pcd_pkg::ACT_ZERO_CROSS, rand_value());
          send_event(pcd_pkg::ACT_TIMEOUT, rand_value());
        end
        sent += 2 * k;
      end else if (r < 88) begin
        case ($urandom_range(0, 9))
          0, 1: send_event(pcd_pkg::ACT_SET_LEVEL, rand_value());
          2: send_event(pcd_pkg::ACT_ON_OFF, $urandom_range(0, 1) ? rand_value() : '0);
          3, 4: send_event(pcd_pkg::ACT_STEP_UP, rand_value());
          5, 6: send_event(pcd_pkg::ACT_STEP_DOWN, rand_value());
          default: send_event(pcd_pkg::ACT_WAKE_UP, rand_value());
        endcase
        sent++;
      end else begin
        send_event(3'($urandom_range(0, 7)), pcd_pkg::LEVEL_W'($urandom_range(0, 127)));
        sent++;
      end
      if (mid_drain && !drained && sent >= budget / 2) begin
        wait_drained();
        drained = 1'b1;
      end
    end
  endtask

  initial begin
    rst         = 1'b1;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = 8'd0;
    s_tvalid    = 1'b0;
    s_tdata     = 16'd0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_event(pcd_pkg::ACT_ZERO_CROSS, 7'd0);
    send_event(pcd_pkg::ACT_TIMEOUT, 7'd127);
    send_event(ACT_UNUSED, 7'd127);
    send_event(pcd_pkg::ACT_STEP_DOWN, 7'd0);
    send_event(pcd_pkg::ACT_ZERO_CROSS, 7'd100);
    send_event(pcd_pkg::ACT_STEP_DOWN, 7'd0);
    send_event(pcd_pkg::ACT_ZERO_CROSS, 7'd0);
    send_event(pcd_pkg::ACT_TIMEOUT, 7'd0);
    send_event(pcd_pkg::ACT_STEP_UP, 7'd0);
    send_event(pcd_pkg::ACT_STEP_UP, 7'd0);
    send_event(pcd_pkg::ACT_STEP_UP, 7'd0);
    send_event(pcd_pkg::ACT_STEP_DOWN, 7'd0);
    send_event(pcd_pkg::ACT_SET_LEVEL, 7'd5);
    send_event(pcd_pkg::ACT_SET_LEVEL, 7'd95);
    send_event(pcd_pkg::ACT_SET_LEVEL, 7'd0);
    send_event(pcd_pkg::ACT_SET_LEVEL, 7'd127);
    send_event(pcd_pkg::ACT_SET_LEVEL, 7'd6);
    send_event(pcd_pkg::ACT_SET_LEVEL, 7'd94);
    send_event(pcd_pkg::ACT_SET_LEVEL, 7'd45);
    send_event(pcd_pkg::ACT_SET_LEVEL, 7'd44);
    send_event(pcd_pkg::ACT_ON_OFF, 7'd1);
    send_event(pcd_pkg::ACT_ON_OFF, 7'd0);
    send_event(pcd_pkg::ACT_WAKE_UP, 7'd0);
    send_event(pcd_pkg::ACT_ZERO_CROSS, 7'd0);
    send_event(pcd_pkg::ACT_TIMEOUT, 7'd0);
    send_event(pcd_pkg::ACT_STEP_UP, 7'd0);
    send_event(pcd_pkg::ACT_STEP_DOWN, 7'd0);

    write_hold(8'd1);
    run_phase(250, 1'b0);
    write_hold(8'd255);
    run_phase(250, 1'b1);
    write_hold(8'd3);
    run_phase(250, 1'b0);
    write_hold(8'd0);
    run_phase(220, 1'b0);
    write_hold(8'd12);
    run_phase(250, 1'b0);
    write_hold(8'd50);
    run_phase(180, 1'b0);

    wait_drained();
    repeat (8) @(posedge clk);
    if (board.fail_count == 0 && board.expected_status.size() == 0) begin
      $display("phase_cut_dimmer_control_top test passed");
    end else begin
      $display("phase_cut_dimmer_control_top test failed");
    end
    $finish;
  end

endmodule
